// ----- sv/ucdw_pkg.sv -----
`timescale 1ns / 1ps
package ucdw_pkg;

  // descriptor type codes
  localparam logic [7:0] TYPE_INTERFACE = 8'd4;
  localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;

  // minimum lengths for a descriptor to be decoded
  localparam logic [7:0] IFACE_MIN_LEN = 8'd9;
  localparam logic [7:0] EP_MIN_LEN    = 8'd7;
  localparam logic [7:0] DESC_MIN_LEN  = 8'd2;

  localparam logic [1:0]  XFER_ISOC   = 2'd1;
  localparam logic [15:0] MAXP_LIMIT  = 16'd1024;
  localparam logic [3:0]  EP_NUM_MASK = 4'hF;

  // configuration register indexes
  localparam logic CFG_KNOWN_CLASS_A = 1'b0;
  localparam logic CFG_KNOWN_CLASS_B = 1'b1;

  typedef struct packed {
    logic [10:0] pkt_size;
    logic [7:0]  interval;
    logic [1:0]  xfer_type;
    logic        dir_in;
    logic [3:0]  number;
  } ep_entry_t;

endpackage

// ----- sv/usb_config_descriptor_walker.sv -----
`timescale 1ns / 1ps
// USB configuration block walker.
//
// Input stream (s_axis_*): one byte of a configuration block per transaction,
// tlast on the final byte that arrived. Descriptors are stepped over by their
// length byte; interface and endpoint descriptors are decoded as their last
// byte is taken, all in the cycle of that byte.
// Output stream (m_axis_*): on the tlast byte a run of results is captured
// into an output buffer and the walk state clears, so the next block may
// start in the very next cycle. The run has one transaction per recorded
// endpoint (one with zeroed endpoint fields if none), tlast on the final one.
// Latency: the first result is valid the cycle after the tlast byte.
// Throughput: one byte per cycle. The output buffer holds one run; it drains
// at one result per cycle, and a tlast byte arriving while a previous run is
// still in the buffer waits (tready low) until that run's final result is
// taken. Bytes without tlast are never stalled.
// Reset: walk state clears, the class registers return to 3 and 8, the output
// buffer is empty. A stalled receiver holds the current result in place.
// Configuration writes take effect at the next byte.
module usb_config_descriptor_walker #(
  parameter int MAX_ENDPOINTS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // byte_value
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // class, subclass, protocol, interface number, interface total,
  // endpoint count, ep number, ep dir, ep type, ep interval, ep packet size
  output logic [71:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o    // last_item
);
  import ucdw_pkg::*;

  localparam int CntW = $clog2(MAX_ENDPOINTS + 1);
  localparam int IdxW = (MAX_ENDPOINTS > 1) ? $clog2(MAX_ENDPOINTS) : 1;

  logic [7:0] class_a_q, class_b_q;

  logic [7:0] offset_q, offset_d;
  logic [7:0] length_q, length_d;
  logic [7:0] type_q, type_d;
  logic [7:0] bytes_q [2:7];
  logic [7:0] bytes_d [2:7];
  logic       halted_q, halted_d;
  logic       have_q, have_d;
  logic       known_q, known_d;
  logic       collect_q, collect_d;
  logic [7:0] seen_q, seen_d;
  logic [31:0] chosen_q, chosen_d;
  ep_entry_t  table_q [MAX_ENDPOINTS];
  ep_entry_t  table_d [MAX_ENDPOINTS];
  logic [CntW-1:0] cnt_q, cnt_d;

  logic            busy_q, busy_d;
  logic [IdxW-1:0] oidx_q, oidx_d;
  logic [CntW-1:0] ocnt_q;
  logic [31:0]     ochosen_q;
  logic [7:0]      oseen_q;
  ep_entry_t       otable_q [MAX_ENDPOINTS];

  logic       in_acc, out_acc, out_last, load;
  logic [7:0] b;
  logic [7:0] v [2:7];
  logic [7:0] typ_v;
  logic       cls_known, finish;
  logic [15:0] maxp;
  ep_entry_t  new_ep;
  ep_entry_t  cur_ep;
  logic [31:0] cnt_ext;

  assign b       = s_axis_tdata_i;
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = busy_q && m_axis_tready_i;
  assign load    = in_acc && s_axis_tlast_i;

  assign out_last = (ocnt_q == '0) || (32'(oidx_q) + 32'd1 == 32'(ocnt_q));
  assign s_axis_tready_o = !busy_q || !s_axis_tlast_i || (m_axis_tready_i && out_last);

  // byte view with the current byte merged in, for the finishing byte
  always_comb begin
    for (int k = 2; k <= 7; k++) begin
      v[k] = (offset_q == 8'(k)) ? b : bytes_q[k];
    end
  end

  assign typ_v     = (offset_q == 8'd1) ? b : type_q;
  assign cls_known = (v[5] == class_a_q) || (v[5] == class_b_q);
  assign finish    = (offset_q == length_q - 8'd1);
  assign maxp      = {v[5], v[4]};

  always_comb begin
    new_ep.number    = v[2][3:0] & EP_NUM_MASK;
    new_ep.dir_in    = v[2][7];
    new_ep.xfer_type = v[3][1:0];
    new_ep.interval  = v[6];
    new_ep.pkt_size  = maxp[10:0];
  end

  always_comb begin
    offset_d  = offset_q;
    length_d  = length_q;
    type_d    = type_q;
    halted_d  = halted_q;
    have_d    = have_q;
    known_d   = known_q;
    collect_d = collect_q;
    seen_d    = seen_q;
    chosen_d  = chosen_q;
    cnt_d     = cnt_q;
    for (int k = 2; k <= 7; k++) bytes_d[k] = bytes_q[k];
    for (int k = 0; k < MAX_ENDPOINTS; k++) table_d[k] = table_q[k];

    if (in_acc && !halted_q) begin
      if (offset_q == 8'd0) begin
        if (b < DESC_MIN_LEN) begin
          halted_d = 1'b1;
        end else begin
          length_d = b;
          offset_d = 8'd1;
        end
      end else begin
        if (offset_q == 8'd1) type_d = b;
        for (int k = 2; k <= 7; k++) begin
          if (offset_q == 8'(k)) bytes_d[k] = b;
        end
        if (finish) begin
          offset_d = 8'd0;
          if (typ_v == TYPE_INTERFACE && length_q >= IFACE_MIN_LEN) begin
            if (v[3] != 8'd0) begin
              collect_d = 1'b0;
            end else begin
              if (seen_q != 8'hFF) seen_d = seen_q + 8'd1;
              if (!have_q || (cls_known && !known_q)) begin
                chosen_d  = {v[2], v[7], v[6], v[5]};
                cnt_d     = '0;
                have_d    = 1'b1;
                known_d   = cls_known;
                collect_d = 1'b1;
              end else begin
                collect_d = 1'b0;
              end
            end
          end else if (typ_v == TYPE_ENDPOINT && collect_q && length_q >= EP_MIN_LEN) begin
            if (new_ep.number != 4'd0 && new_ep.xfer_type != XFER_ISOC &&
                maxp != 16'd0 && maxp <= MAXP_LIMIT &&
                32'(cnt_q) < 32'(MAX_ENDPOINTS)) begin
              table_d[cnt_q[IdxW-1:0]] = new_ep;
              cnt_d = cnt_q + CntW'(1);
            end
          end
        end else begin
          offset_d = offset_q + 8'd1;
        end
      end
    end
  end

  // output buffer control
  always_comb begin
    busy_d = busy_q;
    oidx_d = oidx_q;
    if (out_acc) begin
      if (out_last) begin
        busy_d = 1'b0;
      end else begin
        oidx_d = oidx_q + IdxW'(1);
      end
    end
    if (load) begin
      busy_d = 1'b1;
      oidx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_a_q <= 8'd3;
      class_b_q <= 8'd8;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_KNOWN_CLASS_A: class_a_q <= cfg_wdata_i;
        CFG_KNOWN_CLASS_B: class_b_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q  <= '0;
      length_q  <= '0;
      type_q    <= '0;
      halted_q  <= 1'b0;
      have_q    <= 1'b0;
      known_q   <= 1'b0;
      collect_q <= 1'b0;
      seen_q    <= '0;
      chosen_q  <= '0;
      cnt_q     <= '0;
      busy_q    <= 1'b0;
      oidx_q    <= '0;
    end else begin
      busy_q <= busy_d;
      oidx_q <= oidx_d;
      if (load) begin
        // end of block: walk state returns to its reset values
        offset_q  <= '0;
        length_q  <= '0;
        type_q    <= '0;
        halted_q  <= 1'b0;
        have_q    <= 1'b0;
        known_q   <= 1'b0;
        collect_q <= 1'b0;
        seen_q    <= '0;
        chosen_q  <= '0;
        cnt_q     <= '0;
      end else begin
        offset_q  <= offset_d;
        length_q  <= length_d;
        type_q    <= type_d;
        halted_q  <= halted_d;
        have_q    <= have_d;
        known_q   <= known_d;
        collect_q <= collect_d;
        seen_q    <= seen_d;
        chosen_q  <= chosen_d;
        cnt_q     <= cnt_d;
      end
    end
  end

  // payload storage, no reset needed
  always_ff @(posedge clk_i) begin
    for (int k = 2; k <= 7; k++) bytes_q[k] <= bytes_d[k];
    for (int k = 0; k < MAX_ENDPOINTS; k++) table_q[k] <= table_d[k];
    if (load) begin
      ocnt_q    <= cnt_d;
      ochosen_q <= chosen_d;
      oseen_q   <= seen_d;
      for (int k = 0; k < MAX_ENDPOINTS; k++) otable_q[k] <= table_d[k];
    end
  end

  always_comb begin
    cur_ep = otable_q[oidx_q];
    if (ocnt_q == '0) cur_ep = '0;
  end

  assign cnt_ext = 32'(ocnt_q);

  assign m_axis_tvalid_o = busy_q;
  assign m_axis_tlast_o  = out_last;
  assign m_axis_tdata_o  = {3'b000, cur_ep.pkt_size, cur_ep.interval, cur_ep.xfer_type,
                            cur_ep.dir_in, cur_ep.number, cnt_ext[2:0], oseen_q,
                            ochosen_q};

endmodule

// ----- test/usb_config_descriptor_walker_test.sv -----
`timescale 1ns / 1ps
module usb_config_descriptor_walker_test;
  import ucdw_pkg::*;

  localparam int EP_SLOTS = 4;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } feed_item_t;

  typedef struct {
    logic [71:0] data;
    logic        last;
  } walk_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_addr_i = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'd0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'd0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  usb_config_descriptor_walker #(
    .MAX_ENDPOINTS(EP_SLOTS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // field layout of m_axis_tdata_o
  int    field_lo[11] = '{0, 8, 16, 24, 32, 40, 43, 47, 48, 50, 58};
  int    field_w[11]  = '{8, 8, 8, 8, 8, 3, 4, 1, 2, 8, 11};
  string field_names[11] = '{"if_class", "if_subclass", "if_protocol",
                             "if_number", "if_total", "endpoint_count",
                             "ep_number", "ep_dir_in", "ep_type", "ep_interval",
                             "ep_pkt_size"};

  feed_item_t   byte_feed[$];
  walk_result_t expected_results[$];
  logic [7:0]   blk[$];
  logic [7:0]   desc_body[$];
  int           fed_items = 0;
  int           taken_items = 0;
  int           mismatches = 0;
  logic         quiet_mode = 1'b0;
  int           hold_requested = 0;
  int           hold_served = 0;
  int           sink_hold_cnt = 0;

  // walk state mirrored from the block
  logic [7:0] cls_a = 8'd3;
  logic [7:0] cls_b = 8'd8;
  int         d_off = 0;
  logic [7:0] d_len = 8'd0;
  logic [7:0] d_type = 8'd0;
  logic [7:0] d_bytes[9];
  bit         halted = 1'b0;
  bit         have_if = 1'b0;
  bit         choice_known = 1'b0;
  bit         collecting = 1'b0;
  logic [7:0] seen = 8'd0;
  logic [7:0] ch_cls = 8'd0, ch_sub = 8'd0, ch_proto = 8'd0, ch_num = 8'd0;
  ep_entry_t  ep_tab[EP_SLOTS];
  int         ep_cnt = 0;

  function automatic walk_result_t pack_result(ep_entry_t e, logic [2:0] cnt, logic last);
    walk_result_t r;
    r.data = {3'b000, e, cnt, seen, ch_num, ch_proto, ch_sub, ch_cls};
    r.last = last;
    return r;
  endfunction

  function automatic void close_descriptor();
    bit          known;
    logic [15:0] maxp;
    ep_entry_t   e;
    if (d_type == TYPE_INTERFACE && d_len >= IFACE_MIN_LEN) begin
      if (d_bytes[3] != 8'd0) begin
        collecting = 1'b0;
      end else begin
        known = (d_bytes[5] == cls_a) || (d_bytes[5] == cls_b);
        if (seen != 8'd255) seen++;
        if (!have_if || (known && !choice_known)) begin
          ch_cls = d_bytes[5];
          ch_sub = d_bytes[6];
          ch_proto = d_bytes[7];
          ch_num = d_bytes[2];
          ep_cnt = 0;
          have_if = 1'b1;
          choice_known = known;
          collecting = 1'b1;
        end else begin
          collecting = 1'b0;
        end
      end
    end else if (d_type == TYPE_ENDPOINT && collecting && d_len >= EP_MIN_LEN) begin
      maxp = {d_bytes[5], d_bytes[4]};
      e.number = d_bytes[2][3:0] & EP_NUM_MASK;
      e.dir_in = d_bytes[2][7];
      e.xfer_type = d_bytes[3][1:0];
      e.interval = d_bytes[6];
      e.pkt_size = maxp[10:0];
      if (e.number != 4'd0 && e.xfer_type != XFER_ISOC && maxp != 16'd0 &&
          maxp <= MAXP_LIMIT && ep_cnt < EP_SLOTS) begin
        ep_tab[ep_cnt] = e;
        ep_cnt++;
      end
    end
  endfunction

  // advances the walk by one byte; on the marked last byte queues the run
  function automatic void walk_byte(logic [7:0] b, logic last);
    int k;
    if (!halted) begin
      if (d_off == 0) begin
        if (b < DESC_MIN_LEN) begin
          halted = 1'b1;
        end else begin
          d_len = b;
          d_bytes[0] = b;
          d_off = 1;
        end
      end else begin
        if (d_off == 1) d_type = b;
        if (d_off < 9) d_bytes[d_off] = b;
        if (d_off + 1 == d_len) begin
          close_descriptor();
          d_off = 0;
        end else begin
          d_off++;
        end
      end
    end
    if (last) begin
      if (ep_cnt == 0) begin
        expected_results.push_back(pack_result('0, 3'd0, 1'b1));
      end else begin
        for (k = 0; k < ep_cnt; k++) begin
          expected_results.push_back(pack_result(ep_tab[k], ep_cnt[2:0], k + 1 == ep_cnt));
        end
      end
      d_off = 0;
      d_len = 8'd0;
      d_type = 8'd0;
      halted = 1'b0;
      have_if = 1'b0;
      choice_known = 1'b0;
      collecting = 1'b0;
      seen = 8'd0;
      ch_cls = 8'd0;
      ch_sub = 8'd0;
      ch_proto = 8'd0;
      ch_num = 8'd0;
      ep_cnt = 0;
    end
  endfunction

  function automatic void report_mismatch(string what, longint unsigned want,
                                          longint unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %s: expected 0x%0h, got 0x%0h", what, want, got);
    end
  endfunction

  function automatic void check_result(logic [71:0] data, logic last);
    walk_result_t    want;
    longint unsigned mask;
    int              f;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected transaction", 0, data[63:0]);
    end else begin
      want = expected_results.pop_front();
      for (f = 0; f < 11; f++) begin
        mask = (64'd1 << field_w[f]) - 1;
        if (((want.data >> field_lo[f]) & mask) !== ((data >> field_lo[f]) & mask)) begin
          report_mismatch(field_names[f], 64'((want.data >> field_lo[f]) & mask),
                          64'((data >> field_lo[f]) & mask));
        end
      end
      if (want.last !== last) report_mismatch("last_item", 64'(want.last), 64'(last));
    end
  endfunction

  // byte source
  always @(posedge clk_i) begin : drv_proc
    feed_item_t nxt;
    logic       drive_valid;
    int         src_gap;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      src_gap = 0;
    end else begin
      drive_valid = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        walk_byte(s_axis_tdata_i, s_axis_tlast_i);
        taken_items++;
        drive_valid = 1'b0;
      end
      if (!drive_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (byte_feed.size() > 0) begin
          if (!quiet_mode && $urandom_range(0, 7) == 0) begin
            src_gap = $urandom_range(0, 12);
          end else begin
            nxt = byte_feed.pop_front();
            drive_valid = 1'b1;
            s_axis_tdata_i <= nxt.value;
            s_axis_tlast_i <= nxt.last;
          end
        end
      end
      s_axis_tvalid_i <= drive_valid;
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (sink_hold_cnt > 0) begin
      sink_hold_cnt <= sink_hold_cnt - 1;
    end else if (hold_served != hold_requested) begin
      sink_hold_cnt <= 90;
      hold_served <= hold_served + 1;
    end
  end

  // result sink
  always @(posedge clk_i) begin : mon_proc
    logic ready_next;
    int   sink_gap;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) check_result(m_axis_tdata_o, m_axis_tlast_o);
      if (sink_hold_cnt > 0) begin
        ready_next = 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        ready_next = 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 12);
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      m_axis_tready_i <= ready_next;
    end
  end

  task automatic feed_block();
    feed_item_t it;
    int         i;
    for (i = 0; i < blk.size(); i++) begin
      it.value = blk[i];
      it.last = (i == blk.size() - 1);
      byte_feed.push_back(it);
    end
    fed_items += blk.size();
    blk.delete();
  endtask

  // length byte, then the body, then random filler up to the length
  task automatic emit_desc(int len);
    int i;
    blk.push_back(8'(len));
    for (i = 1; i < len; i++) begin
      if (i - 1 < desc_body.size()) blk.push_back(desc_body[i - 1]);
      else blk.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic add_interface(bit plain);
    int         len;
    int         roll;
    logic [7:0] cls;
    roll = $urandom_range(0, 9);
    len = 9;
    if (!plain && roll == 0) len = $urandom_range(2, 8);
    else if (!plain && roll == 1) len = $urandom_range(10, 14);
    roll = $urandom_range(0, 5);
    if (roll == 0) cls = cls_a;
    else if (roll == 1) cls = cls_b;
    else if (roll == 2) cls = 8'd0;
    else if (roll == 3) cls = 8'd255;
    else cls = 8'($urandom_range(0, 255));
    desc_body.delete();
    desc_body.push_back(TYPE_INTERFACE);
    desc_body.push_back(8'($urandom_range(0, 255)));
    if (!plain && $urandom_range(0, 4) == 0) desc_body.push_back(8'($urandom_range(1, 255)));
    else desc_body.push_back(8'd0);
    desc_body.push_back(8'($urandom_range(0, 4)));
    desc_body.push_back(cls);
    desc_body.push_back(8'($urandom_range(0, 255)));
    desc_body.push_back(8'($urandom_range(0, 255)));
    desc_body.push_back(8'($urandom_range(0, 255)));
    emit_desc(len);
  endtask

  task automatic add_endpoint();
    int          len;
    int          roll;
    logic [15:0] maxp;
    logic [7:0]  addr;
    roll = $urandom_range(0, 9);
    if (roll == 0) maxp = 16'd0;
    else if (roll == 1) maxp = 16'd1024;
    else if (roll == 2) maxp = 16'd1025;
    else if (roll == 3) maxp = 16'($urandom_range(0, 65535));
    else if (roll == 4) maxp = 16'd1;
    else maxp = 16'($urandom_range(1, 1024));
    addr = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) addr[3:0] = 4'd0;
    roll = $urandom_range(0, 9);
    len = (roll == 0) ? $urandom_range(2, 6) : (roll == 1) ? 9 : 7;
    desc_body.delete();
    desc_body.push_back(TYPE_ENDPOINT);
    desc_body.push_back(addr);
    desc_body.push_back(8'($urandom_range(0, 255)));
    desc_body.push_back(maxp[7:0]);
    desc_body.push_back(maxp[15:8]);
    desc_body.push_back(8'($urandom_range(0, 255)));
    emit_desc(len);
  endtask

  // mostly well-formed configuration blocks, some noise, halts and truncations
  task automatic gen_block();
    int n;
    int i;
    int roll;
    int keep;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 16);
      for (i = 0; i < n; i++) blk.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) != 0) begin
        desc_body.delete();
        desc_body.push_back(8'd2);
        emit_desc(9);
      end
      n = $urandom_range(0, 7);
      for (i = 0; i < n; i++) begin
        roll = $urandom_range(0, 9);
        if (roll <= 2) begin
          add_interface(1'b0);
        end else if (roll <= 6) begin
          add_endpoint();
        end else if (roll == 9 && $urandom_range(0, 2) == 0) begin
          blk.push_back(8'($urandom_range(0, 1)));
        end else begin
          desc_body.delete();
          roll = $urandom_range(0, 3);
          desc_body.push_back(roll == 0 ? 8'h21 : roll == 1 ? 8'h24 : roll == 2 ? 8'h0B :
                              8'($urandom_range(0, 255)));
          emit_desc($urandom_range(2, 12));
        end
      end
      if (blk.size() == 0) blk.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 5) == 0) begin
        keep = $urandom_range(1, blk.size());
        while (blk.size() > keep) void'(blk.pop_back());
      end
    end
    feed_block();
  endtask

  task automatic write_class(logic idx, logic [7:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= v;
    if (idx == CFG_KNOWN_CLASS_A) cls_a = v;
    else cls_b = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    while (taken_items != fed_items || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : stim_proc
    int         i;
    int         n;
    logic [7:0] v;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // halt on the first byte, a lone length byte, one full interface with an
    // endpoint at the edges, and a halt after a short descriptor
    blk.push_back(8'h00);
    feed_block();
    blk.push_back(8'hFF);
    feed_block();
    blk = '{8'd9, TYPE_INTERFACE, 8'h01, 8'h00, 8'h01, 8'h03, 8'h01, 8'h02, 8'h00,
            8'd7, TYPE_ENDPOINT, 8'h8F, 8'h03, 8'h00, 8'h04, 8'hFF};
    feed_block();
    blk = '{8'd2, 8'h21, 8'h01, 8'hAA};
    feed_block();
    settle();

    while (fed_items < 100) gen_block();
    settle();

    // stall the receiver while short runs keep coming
    hold_requested <= hold_requested + 1;
    for (i = 0; i < 10; i++) begin
      n = $urandom_range(1, 3);
      repeat (n) blk.push_back(8'($urandom_range(0, 255)));
      feed_block();
    end
    settle();

    write_class(CFG_KNOWN_CLASS_A, 8'd0);
    write_class(CFG_KNOWN_CLASS_B, 8'd255);
    while (fed_items < 180) gen_block();
    settle();

    write_class(CFG_KNOWN_CLASS_A, 8'd255);
    write_class(CFG_KNOWN_CLASS_B, 8'd0);
    while (fed_items < 250) gen_block();
    settle();

    v = 8'($urandom_range(0, 255));
    write_class(CFG_KNOWN_CLASS_A, v);
    write_class(CFG_KNOWN_CLASS_B, v);
    quiet_mode <= 1'b1;
    while (fed_items < 265) gen_block();

    // a chosen interface with an endpoint, then more interfaces to count
    add_interface(1'b1);
    add_endpoint();
    for (i = 0; i < 3; i++) add_interface(1'b1);
    feed_block();
    settle();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
